// File: rtl/ssvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse SVM update package
// Shared widths, codes and arithmetic helpers for the sparse SVM trainer.
// ----------------------------------------------------------------------------
package ssvm_pkg;

    localparam int DimW   = 12;
    localparam int RowW   = 6;
    localparam int CntW   = 7;
    localparam int RowMax = 64;
    localparam int RowEntW = 44;

    localparam logic [1:0] OP_ELEM = 2'd0;
    localparam logic [1:0] OP_PASS = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] KIND_ROW  = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_PASS = 2'd2;

    localparam logic [1:0] CFG_STEP  = 2'd0;
    localparam logic [1:0] CFG_MU    = 2'd1;
    localparam logic [1:0] CFG_DECAY = 2'd2;

    typedef struct packed {
        logic start;
        logic [23:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// File: rtl/ssvm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module ssvm_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/ssvm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 24 by 16 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssvm_div (
    input  logic                clk,
    input  logic                rst_n,
    input  ssvm_pkg::div_req_t  req,
    output logic                done,
    output logic [23:0]         quotient
);

    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [23:0] q_reg, q_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic [16:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg[15:0], q_reg[23]};
        done      = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            q_next    = req.dividend;
            rem_next  = 17'd0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[22:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                q_next[0] = 1'b1;
            end
            else
                rem_next = trial;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
        quotient = q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

// File: rtl/sparse_svm_sgd_update_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse SVM SGD update
// Trains a linear SVM by stochastic gradient descent on sparse rows.
// ----------------------------------------------------------------------------
// A non-last element holds busy through the weight read and accumulate states;
// a read or an end of pass strobes its result once back in idle, when the next
// word may be taken. A last element also runs the gradient walk when the hinge
// fires, then the shrink walk, whose serial divide per element sets its length.
// After reset a clearing pass zeroes all 4096 weight words, during
// which busy is held high. The receiver cannot stall: results are strobed.
module sparse_svm_sgd_update_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [11:0] feature_index,
    input  logic signed [15:0] feature_value,
    input  logic [15:0] feature_degree,
    input  logic        row_label,
    input  logic        last_element,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output logic        result_valid,
    output logic [1:0]  result_kind,
    output logic signed [31:0] row_margin,
    output logic        hinge_active,
    output logic signed [31:0] weight_value,
    output logic [23:0] current_step
);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ERD   = 4'd2;  // element: weight being read
    localparam logic [3:0] S_EACC  = 4'd3;  // element: accumulate
    localparam logic [3:0] S_GRD   = 4'd4;  // gradient walk: read buffer
    localparam logic [3:0] S_GWR   = 4'd5;  // gradient walk: read weight
    localparam logic [3:0] S_GUP   = 4'd6;  // gradient walk: write weight
    localparam logic [3:0] S_SRD   = 4'd7;  // shrink walk: read buffer
    localparam logic [3:0] S_SDIV  = 4'd8;  // shrink walk: divide, read weight
    localparam logic [3:0] S_SMUL  = 4'd9;  // shrink walk: product
    localparam logic [3:0] S_SWR   = 4'd10; // shrink walk: write weight
    localparam logic [3:0] S_RRD   = 4'd11; // read item
    localparam logic [3:0] S_PMUL  = 4'd12; // end of pass
    localparam logic [3:0] S_DONE  = 4'd13; // row result

    logic [3:0]  state_reg, state_next;
    logic [23:0] init_step_reg, mu_reg, decay_reg;
    logic [23:0] step_reg, step_next;
    logic [6:0]  count_reg, count_next;
    logic signed [47:0] acc_reg, acc_next;
    logic [6:0]  walk_reg, walk_next;
    logic [11:0] clr_reg, clr_next;
    logic        divbusy_reg;

    // Latched item.
    logic [11:0] idx_reg;
    logic signed [15:0] val_reg;
    logic [15:0] deg_reg;
    logic        lab_reg, last_reg, drop_reg;

    // Row finish data.
    logic signed [31:0] margin_reg;
    logic        hinge_reg;
    logic [23:0] scalar_reg;
    logic signed [31:0] prod_reg;
    logic [23:0] factor_reg;
    logic        fac_one_reg;

    // Result registers.
    logic        rv_reg;
    logic [1:0]  rk_reg;
    logic signed [31:0] rm_reg, rw_reg;
    logic        rh_reg;
    logic [23:0] rs_reg;

    // Weight memory and row buffer.
    logic        w_we;
    logic [11:0] w_waddr, w_raddr;
    logic [31:0] w_wdata, w_rdata;
    logic        b_we;
    logic [5:0]  b_waddr, b_raddr;
    logic [43:0] b_wdata, b_rdata;

    ssvm_ram #(.Width(32), .Depth(4096)) u_wmem (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    ssvm_ram #(.Width(ssvm_pkg::RowEntW), .Depth(ssvm_pkg::RowMax)) u_bmem (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    ssvm_pkg::div_req_t div_req;
    logic        div_done;
    logic [23:0] div_q;

    ssvm_div u_div (
        .clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .quotient(div_q)
    );

    // Buffer entry fields: index, value, degree.
    logic [11:0] b_idx;
    logic signed [15:0] b_val;
    logic [15:0] b_deg;
    assign b_idx = b_rdata[43:32];
    assign b_val = b_rdata[31:16];
    assign b_deg = b_rdata[15:0];

    // Arithmetic between registers.
    logic signed [47:0] dot_term;
    logic signed [48:0] acc_sum;
    logic signed [63:0] wprod;
    logic signed [39:0] gprod;
    logic signed [32:0] grad;
    logic signed [33:0] wsum;
    logic [47:0] stepmu;
    logic [47:0] stepdec;
    logic signed [48:0] negacc;
    logic signed [31:0] margin_now;
    logic        hinge_now;
    // Factor is at most 2^24, so it needs 25 bits unsigned, 26 bits signed.
    logic [24:0] fac25;
    logic signed [57:0] sprod2;

    assign wprod    = 64'(val_reg * $signed(w_rdata));
    assign dot_term = 48'(wprod >>> 12);
    assign acc_sum  = 49'(acc_reg) + 49'(dot_term);
    assign gprod    = $signed({16'd0, step_reg}) * 40'(b_val);
    assign grad     = lab_reg ? 33'(gprod >>> 12) : -33'(gprod >>> 12);
    assign wsum     = 34'($signed(w_rdata)) + 34'(grad);
    assign stepmu   = step_reg * mu_reg;
    assign stepdec  = step_reg * decay_reg;
    assign negacc   = lab_reg ? 49'(acc_reg) : -49'(acc_reg);
    assign margin_now = ssvm_pkg::sat32(64'(negacc));
    assign hinge_now  = (margin_now < 32'sh01000000);
    assign fac25    = fac_one_reg ? 25'h1000000 : {1'b0, factor_reg};
    assign sprod2   = 58'($signed(w_rdata)) * 58'($signed({1'b0, fac25}));

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        walk_next  = walk_reg;
        clr_next   = clr_reg;
        w_we = 1'b0; w_waddr = 12'd0; w_wdata = 32'd0; w_raddr = idx_reg;
        b_we = 1'b0; b_waddr = count_reg[5:0];
        b_wdata = {idx_reg, val_reg, deg_reg};
        b_raddr = walk_reg[5:0];
        div_req = '0;
        case (state_reg)
            S_CLEAR:
            begin
                w_we = 1'b1; w_waddr = clr_reg;
                clr_next = clr_reg + 12'd1;
                if (clr_reg == 12'hfff)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                w_raddr = feature_index;
                if (start)
                begin
                    case (opcode)
                        ssvm_pkg::OP_ELEM: state_next = S_ERD;
                        ssvm_pkg::OP_PASS: state_next = S_PMUL;
                        ssvm_pkg::OP_READ: state_next = S_RRD;
                        default:           state_next = S_IDLE;
                    endcase
                end
            end
            S_ERD:
            begin
                // Weight read issued in idle lands now; hold its address.
                state_next = S_EACC;
            end
            S_EACC:
            begin
                if (!drop_reg)
                begin
                    b_we = 1'b1;
                    count_next = count_reg + 7'd1;
                    if (acc_sum > 49'sh7fffffffffff)
                        acc_next = 48'sh7fffffffffff;
                    else if (acc_sum < -49'sh800000000000)
                        acc_next = 48'sh800000000000;
                    else
                        acc_next = acc_sum[47:0];
                end
                walk_next = 7'd0;
                state_next = last_reg ? S_DONE : S_IDLE;
            end
            S_DONE:
            begin
                // Margin settled; start the gradient walk or go to shrink.
                if (hinge_now && count_reg != 7'd0)
                begin
                    walk_next = 7'd0;
                    state_next = S_GRD;
                end
                else
                begin
                    walk_next = count_reg;
                    state_next = S_SRD;
                end
            end
            S_GRD:
            begin
                b_raddr = walk_reg[5:0];
                state_next = S_GWR;
            end
            S_GWR:
            begin
                w_raddr = b_idx;
                state_next = S_GUP;
            end
            S_GUP:
            begin
                w_we = 1'b1; w_waddr = b_idx;
                w_wdata = ssvm_pkg::sat32(64'(wsum));
                walk_next = walk_reg + 7'd1;
                if (walk_reg + 7'd1 == count_reg)
                begin
                    walk_next = count_reg;
                    state_next = S_SRD;
                end
                else
                    state_next = S_GRD;
            end
            S_SRD:
            begin
                if (walk_reg == 7'd0)
                begin
                    // Row closed: clear the buffer count and the dot product.
                    count_next = 7'd0;
                    acc_next   = 48'sd0;
                    state_next = S_IDLE;
                end
                else
                begin
                    b_raddr = walk_reg[5:0] - 6'd1;
                    walk_next = walk_reg - 7'd1;
                    state_next = S_SDIV;
                    div_req.start = 1'b0;
                end
            end
            S_SDIV:
            begin
                w_raddr = b_idx;
                if (!divbusy_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = scalar_reg;
                    div_req.divisor  = (b_deg == 16'd0) ? 16'd1 : b_deg;
                end
                else if (div_done)
                    state_next = S_SMUL;
            end
            S_SMUL:
            begin
                w_raddr = b_idx;
                state_next = S_SWR;
            end
            S_SWR:
            begin
                w_raddr = b_idx;
                w_we = 1'b1; w_waddr = b_idx; w_wdata = prod_reg;
                state_next = S_SRD;
            end
            S_RRD:
            begin
                state_next = S_IDLE;
            end
            S_PMUL:
            begin
                step_next = stepdec[47:24];
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= 12'd0;
            init_step_reg <= 24'd1677722;
            mu_reg        <= 24'd16777;
            decay_reg     <= 24'd16106127;
            step_reg      <= 24'd1677722;
            count_reg     <= 7'd0;
            acc_reg       <= 48'sd0;
            walk_reg      <= 7'd0;
            rv_reg        <= 1'b0;
            divbusy_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            walk_reg  <= walk_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ssvm_pkg::CFG_STEP:  init_step_reg <= cfg_data;
                    ssvm_pkg::CFG_MU:    mu_reg        <= cfg_data;
                    ssvm_pkg::CFG_DECAY: decay_reg     <= cfg_data;
                    default: ;
                endcase
            end
            // Divider in flight while in the divide state.
            if (state_reg == S_SDIV)
                divbusy_reg <= !div_done;
            else
                divbusy_reg <= 1'b0;
            rv_reg <= (state_reg == S_RRD) || (state_reg == S_PMUL) ||
                      (state_reg == S_SRD && walk_reg == 7'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            idx_reg  <= feature_index;
            val_reg  <= feature_value;
            deg_reg  <= feature_degree;
            lab_reg  <= row_label;
            last_reg <= last_element;
            drop_reg <= (count_reg == 7'(ssvm_pkg::RowMax));
        end
        if (state_reg == S_DONE)
        begin
            margin_reg <= margin_now;
            hinge_reg  <= hinge_now;
            scalar_reg <= stepmu[47:24];
        end
        if (div_done)
        begin
            factor_reg  <= 24'(25'h1000000 - {1'b0, div_q});
            fac_one_reg <= (div_q == 24'd0);
        end
        if (state_reg == S_SMUL)
            prod_reg <= ssvm_pkg::sat32(64'(sprod2 >>> 24));
        if (state_reg == S_RRD)
        begin
            rk_reg <= ssvm_pkg::KIND_READ;
            rm_reg <= 32'sd0; rh_reg <= 1'b0;
            rw_reg <= w_rdata; rs_reg <= step_reg;
        end
        if (state_reg == S_PMUL)
        begin
            rk_reg <= ssvm_pkg::KIND_PASS;
            rm_reg <= 32'sd0; rh_reg <= 1'b0;
            rw_reg <= 32'sd0; rs_reg <= stepdec[47:24];
        end
        if (state_reg == S_SRD && walk_reg == 7'd0)
        begin
            rk_reg <= ssvm_pkg::KIND_ROW;
            rm_reg <= margin_reg; rh_reg <= hinge_reg;
            rw_reg <= 32'sd0; rs_reg <= step_reg;
        end
    end

    // A word is taken whenever the sequencer is idle; a result strobe going out
    // in the same cycle does not hold the input off.
    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign result_valid = rv_reg;
    assign result_kind  = rk_reg;
    assign row_margin   = rm_reg;
    assign hinge_active = rh_reg;
    assign weight_value = rw_reg;
    assign current_step = rs_reg;

    // The initial step register is never read; the step register is reset to the
    // same constant directly, so a step written through the config port is unused.
    logic unused_ok;
    assign unused_ok = ^{init_step_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GUP) |-> (walk_reg < count_reg))
        else $error("gradient walk beyond row");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= 7'(ssvm_pkg::RowMax)))
        else $error("row count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> busy)
        else $error("item accepted during clear");

endmodule
